/* rtl/csmm_pkg.sv */
`default_nettype none

package csmm_pkg;

  // Widths of the external fields.
  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int OUT_W    = 24;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCALE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START   = 2'd2;

  // Top of the stretch range and saturation limit of the result.
  localparam logic [CFG_W-1:0] STRETCH_TOP = 16'd255;
  localparam logic [OUT_W-1:0] OUT_MAX     = 24'hFFFFFF;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_WAIT = 3'b100
  } csmm_state_t;

endpackage

`default_nettype wire

/* rtl/csmm_front.sv */
`default_nettype none

module csmm_front #(
  parameter int SAMPLE_BITS = csmm_pkg::SAMPLE_BITS_DEF,
  parameter int ENT_W       = 2 * SAMPLE_BITS + csmm_pkg::CFG_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [csmm_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [csmm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          cfg_valid,
  input  wire logic [csmm_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [ENT_W-1:0]                   q_wdata
);
  import csmm_pkg::*;

  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                   seen_r, seen_nxt;
  logic [CFG_W-1:0]       target_r;
  logic [SAMPLE_BITS-1:0] x;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] mul_a;
  logic [CFG_W-1:0]       mul_b;
  logic [SAMPLE_BITS-1:0] den;
  logic                   degen;

  assign x        = SAMPLE_BITS'(in_sample);
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Operands for the back end are snapshotted from the statistics as they
  // stand when the scale item arrives.
  always_comb begin
    if (target_r == '0) begin
      mul_a = (x > min_r) ? (x - min_r) : '0;
      mul_b = STRETCH_TOP;
      den   = max_r - min_r;
      degen = !seen_r || (max_r <= min_r);
    end else begin
      mul_a = x;
      mul_b = target_r;
      den   = max_r;
      degen = (max_r == '0);
    end
  end

  assign q_push  = accept && (in_kind == KIND_SCALE);
  assign q_wdata = {degen, den, mul_b, mul_a};

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    seen_nxt = seen_r;
    if (accept) begin
      case (in_kind)
        KIND_MEASURE: begin
          if (x < min_r) min_nxt = x;
          if (x > max_r) max_nxt = x;
          seen_nxt = 1'b1;
        end
        KIND_START: begin
          min_nxt  = '1;
          max_nxt  = '0;
          seen_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '1;
      max_r    <= '0;
      seen_r   <= 1'b0;
      target_r <= '0;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      seen_r <= seen_nxt;
      if (cfg_valid) target_r <= cfg_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/csmm_queue.sv */
`default_nettype none

module csmm_queue #(
  parameter int ENT_W = 49
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [ENT_W-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  rvalid,
  output logic [ENT_W-1:0]      rdata
);

  localparam int DEPTH = 2;

  logic [ENT_W-1:0] mem_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'(DEPTH));
  assign rvalid  = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    else if (!do_push && do_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

/* rtl/csmm_back.sv */
`default_nettype none

module csmm_back #(
  parameter int SAMPLE_BITS = csmm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = csmm_pkg::FRAC_BITS_DEF,
  parameter int ENT_W       = 2 * SAMPLE_BITS + csmm_pkg::CFG_W + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire logic [ENT_W-1:0]           q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [csmm_pkg::OUT_W-1:0]      out_scaled_value,
  output logic                            out_degenerate
);
  import csmm_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + CFG_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W);

  csmm_state_t            state_r, state_nxt;
  logic [NUM_W-1:0]       dvd_r, dvd_nxt;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [OUT_W-1:0]       res_r, res_nxt;
  logic                   res_degen_r, res_degen_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_value_r, out_value_nxt;
  logic                   out_degen_r, out_degen_nxt;

  logic [SAMPLE_BITS-1:0] j_mul_a;
  logic [CFG_W-1:0]       j_mul_b;
  logic [SAMPLE_BITS-1:0] j_den;
  logic                   j_degen;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS:0]   rem_sh;
  logic                   q_bit;
  logic [NUM_W-1:0]       quot;
  logic                   out_free;

  assign {j_degen, j_den, j_mul_b, j_mul_a} = q_rdata;
  assign prod = PROD_W'(j_mul_a) * PROD_W'(j_mul_b);

  // One restoring division step per cycle; quotient bits shift in from the
  // bottom of the dividend register.
  assign rem_sh = {rem_r, dvd_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});
  assign quot   = {dvd_r[NUM_W-2:0], q_bit};

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    res_degen_nxt = res_degen_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_degen_nxt = out_degen_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          dvd_nxt = NUM_W'(prod) << FRAC_BITS;
          rem_nxt = '0;
          den_nxt = j_den;
          cnt_nxt = CNT_W'(NUM_W - 1);
          if (j_degen) begin
            res_nxt       = '0;
            res_degen_nxt = 1'b1;
            state_nxt     = ST_WAIT;
          end else begin
            res_degen_nxt = 1'b0;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? SAMPLE_BITS'(rem_sh - {1'b0, den_r}) : rem_sh[SAMPLE_BITS-1:0];
        dvd_nxt = quot;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          res_nxt   = (quot > NUM_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(quot);
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_degen_nxt = res_degen_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    res_degen_r <= res_degen_nxt;
    out_value_r <= out_value_nxt;
    out_degen_r <= out_degen_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_scaled_value = out_value_r;
  assign out_degenerate   = out_degen_r;

endmodule

`default_nettype wire

/* rtl/contrast_stretch_min_max_core.sv */
`default_nettype none

// Channel | Handshake          | Payload
// --------+--------------------+----------------------------------------
// in      | in_valid/in_stall  | in_kind (2), in_sample (16)
// out     | out_valid/out_stall| out_scaled_value (24), out_degenerate (1)
// cfg     | cfg_valid/cfg_ready| cfg_data (16): target maximum
//
// Measure, start and unused items stay in the front end and leave no result.
// A scale item is loaded into the one-bit restoring divider, which forms
// SAMPLE_BITS + 16 + FRAC_BITS quotient bits (40 by default) before handoff;
// a degenerate item skips the divider. A two-entry queue sits between the two
// halves, and in_stall is high only while it is full. Reset is synchronous and
// leaves the minimum at all ones, the maximum and target at zero.

module contrast_stretch_min_max_core #(
  parameter int SAMPLE_BITS = csmm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = csmm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [csmm_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [csmm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [csmm_pkg::OUT_W-1:0]         out_scaled_value,
  output logic                               out_degenerate,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [csmm_pkg::CFG_W-1:0]    cfg_data
);
  import csmm_pkg::*;

  localparam int ENT_W = 2 * SAMPLE_BITS + CFG_W + 1;

  logic             q_full;
  logic             q_push;
  logic [ENT_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_valid;
  logic [ENT_W-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  csmm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  csmm_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  csmm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_degenerate   (out_degenerate)
  );

endmodule

`default_nettype wire

/* verif/contrast_stretch_min_max_core_tb.sv */
`default_nettype none

module contrast_stretch_min_max_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csmm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int FRAC        = FRAC_BITS_DEF;
  // Time through the divider, including load and handoff, without output stalls.
  localparam int DIV_CYCLES  = SAMPLE_BITS_DEF + 16 + FRAC_BITS_DEF + 2;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_LIMIT  = 3000;

  typedef struct packed {
    logic [OUT_W-1:0] scaled;
    logic             degen;
  } stretch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = KIND_MEASURE;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_W-1:0]    out_scaled_value;
  logic                out_degenerate;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  // Mirror of the block's statistics and target register.
  logic [SAMPLE_W-1:0] stat_min = '1;
  logic [SAMPLE_W-1:0] stat_max = '0;
  logic                stat_seen = 1'b0;
  logic [CFG_W-1:0]    target_reg = '0;

  stretch_result_t pending_scaled[$];

  int  items_sent = 0;
  int  fail_count = 0;
  int  quiet_cycles = 0;
  // Long holds requested by the test sequence and those already served.
  int  hold_req = 0;
  int  hold_done = 0;
  bit  sender_gaps = 1'b0;
  bit  stall_bursts = 1'b0;

  contrast_stretch_min_max_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_degenerate   (out_degenerate),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Saturated floor(num * 2^FRAC / den) for a nonzero divisor.
  function automatic logic [OUT_W-1:0] sat_fixed_div(input longint unsigned num,
                                                     input longint unsigned den);
    longint unsigned whole;
    longint unsigned rest;
    longint unsigned val;
    whole = num / den;
    rest  = num % den;
    if (whole > (OUT_MAX >> FRAC)) return OUT_MAX;
    val = (whole << FRAC) + ((rest << FRAC) / den);
    return (val > OUT_MAX) ? OUT_MAX : val[OUT_W-1:0];
  endfunction

  function automatic void stretch_predict(input logic [KIND_W-1:0] kind,
                                          input logic [SAMPLE_W-1:0] x);
    stretch_result_t r;
    r = '0;
    case (kind)
      KIND_START: begin
        stat_min  = '1;
        stat_max  = '0;
        stat_seen = 1'b0;
      end
      KIND_MEASURE: begin
        if (x < stat_min) stat_min = x;
        if (x > stat_max) stat_max = x;
        stat_seen = 1'b1;
      end
      KIND_SCALE: begin
        if (target_reg == '0) begin
          if (!stat_seen || stat_max <= stat_min) begin
            r.degen = 1'b1;
          end else if (x > stat_min) begin
            r.scaled = sat_fixed_div(64'(STRETCH_TOP) * 64'(x - stat_min),
                                     64'(stat_max - stat_min));
          end
        end else if (stat_max == '0) begin
          r.degen = 1'b1;
        end else begin
          r.scaled = sat_fixed_div(64'(target_reg) * 64'(x), 64'(stat_max));
        end
        pending_scaled.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip16(input longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // Offers one item, waits for the transfer, then maybe leaves a gap.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] sample);
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= sample;
    do @(posedge clk); while (in_stall);
    stretch_predict(kind, sample);
    if (kind != KIND_UNUSED) items_sent++;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic sender_pause();
    if (in_valid) in_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
  endtask

  // Measure items leave no result, so allow the divider to finish before writing.
  task automatic write_target(input logic [CFG_W-1:0] value);
    sender_pause();
    repeat (DIV_CYCLES + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    target_reg = value;
  endtask

  task automatic test_directed_stretch();
    write_target(16'd0);
    send_item(KIND_SCALE, 16'h1234);     // nothing measured yet
    send_item(KIND_UNUSED, 16'hFFFF);    // ignored
    send_item(KIND_MEASURE, 16'h0000);
    send_item(KIND_MEASURE, 16'hFFFF);
    send_item(KIND_SCALE, 16'h0000);
    send_item(KIND_SCALE, 16'hFFFF);
    send_item(KIND_SCALE, 16'h0001);
    send_item(KIND_START, 16'hFFFF);
    send_item(KIND_MEASURE, 16'd100);
    send_item(KIND_MEASURE, 16'd100);
    send_item(KIND_SCALE, 16'd100);      // max equal to min
    send_item(KIND_MEASURE, 16'd200);
    send_item(KIND_SCALE, 16'd50);       // below the minimum
    send_item(KIND_SCALE, 16'd150);
    send_item(KIND_START, 16'h0000);
    send_item(KIND_MEASURE, 16'd1000);
    send_item(KIND_MEASURE, 16'd1001);
    send_item(KIND_SCALE, 16'hFFFF);     // far above the maximum, saturates
  endtask

  task automatic test_directed_target();
    write_target(16'hFFFF);
    send_item(KIND_START, 16'h5A5A);
    send_item(KIND_SCALE, 16'd7);        // maximum still zero
    send_item(KIND_MEASURE, 16'd1);
    send_item(KIND_SCALE, 16'hFFFF);
    send_item(KIND_MEASURE, 16'hFFFF);
    send_item(KIND_SCALE, 16'hFFFF);
    send_item(KIND_SCALE, 16'd3);
  endtask

  // The receiver holds off long enough for the internal queue to fill and stall
  // the input, then the sender waits for everything to drain.
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    stall_bursts = 1'b0;
    write_target(16'd0);
    hold_req++;
    send_item(KIND_START, 16'h0000);
    send_item(KIND_MEASURE, 16'd10);
    send_item(KIND_MEASURE, 16'd5000);
    repeat (20) send_item(KIND_SCALE, SAMPLE_W'($urandom_range(0, 6000)));
    sender_pause();
    repeat (5) send_item(KIND_SCALE, SAMPLE_W'($urandom));
    sender_pause();
  endtask

  // Mostly well-formed frames (start, measures, scales) with random content,
  // mixed with bursts of arbitrary items.
  task automatic test_random_frames(input logic [CFG_W-1:0] target, input int n_items);
    int stop_at;
    int lo;
    int span;
    write_target(target);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        lo = $urandom_range(0, 65535);
        case ($urandom_range(0, 5))
          0:       span = 0;
          1:       span = 1;
          2:       span = 15;
          3:       span = 255;
          4:       span = 4095;
          default: span = 65535;
        endcase
        // Now and then the frame start is left out so statistics carry over.
        if ($urandom_range(0, 7) != 0) send_item(KIND_START, SAMPLE_W'($urandom));
        repeat ($urandom_range(0, 9))
          send_item(KIND_MEASURE, clip16(longint'(lo) + longint'($urandom_range(0, span))));
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 7))
            0:       send_item(KIND_SCALE, SAMPLE_W'($urandom));
            1:       send_item(KIND_SCALE, 16'h0000);
            2:       send_item(KIND_SCALE, 16'hFFFF);
            3:       send_item(KIND_SCALE, stat_min);
            4:       send_item(KIND_SCALE, stat_max);
            default: send_item(KIND_SCALE, clip16(longint'(lo) - 2 +
                                 longint'($urandom_range(0, span + span / 2 + 4))));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_item(KIND_W'($urandom), SAMPLE_W'($urandom));
      end
    end
  endtask

  task automatic test_quiet_tail();
    sender_gaps  = 1'b0;
    stall_bursts = 1'b0;
    test_random_frames(16'd0, 200);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_stretch();
    test_directed_target();
    test_backpressure();
    sender_gaps  = 1'b1;
    stall_bursts = 1'b1;
    test_random_frames(16'd0, 200);
    test_random_frames(16'hFFFF, 150);
    test_random_frames(16'd1, 100);
    test_random_frames(CFG_W'($urandom), 200);
    test_random_frames(16'd255, 150);
    test_quiet_tail();
    sender_pause();
    repeat (2 * DIV_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver stall: one long hold when requested, otherwise random bursts.
  always begin
    @(posedge clk);
    if (hold_done != hold_req) begin
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      hold_done++;
      out_stall <= 1'b0;
    end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    stretch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scaled.size() == 0) begin
        $error("unexpected result: scaled_value %0h degenerate %0b",
               out_scaled_value, out_degenerate);
        fail_count++;
      end else begin
        want = pending_scaled.pop_front();
        if (out_scaled_value !== want.scaled) begin
          $error("scaled_value: expected %0h, got %0h", want.scaled, out_scaled_value);
          fail_count++;
        end
        if (out_degenerate !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, out_degenerate);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* contrast_stretch_min_max_core.f */
rtl/csmm_pkg.sv
rtl/csmm_front.sv
rtl/csmm_queue.sv
rtl/csmm_back.sv
rtl/contrast_stretch_min_max_core.sv
verif/contrast_stretch_min_max_core_tb.sv
